// ----- rtl/core/skcf_pkg.sv -----
// Shared types, constants and helpers for the Sallen-Key crossover filter.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package skcf_pkg;

  localparam int unsigned FIXED_RES = 16500;
  localparam int unsigned HALF_RES  = 8250;
  localparam int unsigned RES_W     = $clog2(FIXED_RES);

  localparam logic signed [63:0] S64_MAX     = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN     = {1'b1, 63'd0};
  localparam logic signed [63:0] FIXED_RES_Q = {32'(FIXED_RES), 32'd0};
  localparam logic signed [63:0] HALF_RES_Q  = {32'(HALF_RES), 32'd0};

  typedef enum logic [3:0] {
    STEP_NODE  = 4'd0,
    STEP_IN    = 4'd1,
    STEP_ST1   = 4'd2,
    STEP_ST2   = 4'd3,
    STEP_GAIN  = 4'd4,
    STEP_CRES  = 4'd5,
    STEP_DIFF1 = 4'd6,
    STEP_CAP1  = 4'd7,
    STEP_DIFF2 = 4'd8,
    STEP_CAP2  = 4'd9
  } step_e;

  typedef enum logic [2:0] {MA_S, MA_C1, MA_C2, MA_VO, MA_TWO_RC} mul_a_e;
  typedef enum logic [2:0] {MB_HALF, MB_GIN, MB_GS1, MB_GS2, MB_NODE, MB_RES, MB_DIFF} mul_b_e;
  typedef enum logic [2:0] {AX_M, AX_ACC, AX_VO, AX_VA, AX_S} alu_x_e;
  typedef enum logic [2:0] {AY_ZERO, AY_M, AY_VO, AY_VA, AY_C1, AY_C2} alu_y_e;
  typedef enum logic [2:0] {
    DST_NODE, DST_ACC, DST_VO, DST_VA, DST_DIFF, DST_CAP1, DST_CAP2
  } dst_e;

  typedef struct packed {
    logic   uses_mul;
    mul_a_e a_sel;
    mul_b_e b_sel;
    alu_x_e x_sel;
    alu_y_e y_sel;
    logic   sub;
    dst_e   dst;
  } op_t;

  typedef struct packed {
    logic load_in;
    logic mul_go;
    logic alu_en;
    logic lo_latch;
    logic out_load;
    logic band;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_busy;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic signed [63:0] low_gain_in;
    logic signed [63:0] low_gain_state_one;
    logic signed [63:0] low_gain_state_two;
    logic signed [63:0] high_gain_in;
    logic signed [63:0] high_gain_state_one;
    logic signed [63:0] high_gain_state_two;
    logic [62:0]        cap_resistance;
    logic [62:0]        two_over_cap_resistance;
  } coef_t;

  function automatic logic signed [63:0] sat_addsub(input logic signed [63:0] x,
                                                    input logic signed [63:0] y,
                                                    input logic sub);
    logic signed [64:0] r;
    logic signed [63:0] res;
    if (sub) begin
      r = {x[63], x} - {y[63], y};
    end else begin
      r = {x[63], x} + {y[63], y};
    end
    if (r[64] != r[63]) begin
      res = r[64] ? S64_MIN : S64_MAX;
    end else begin
      res = r[63:0];
    end
    return res;
  endfunction

  // band low = lowpass, high = highpass
  function automatic op_t step_op(input step_e step, input logic band);
    op_t op;
    op.uses_mul = 1'b1;
    op.a_sel    = MA_TWO_RC;
    op.b_sel    = MB_DIFF;
    op.x_sel    = AX_M;
    op.y_sel    = AY_ZERO;
    op.sub      = 1'b0;
    op.dst      = DST_ACC;
    case (step)
      STEP_NODE: begin
        op.b_sel = MB_HALF;
        op.dst   = DST_NODE;
      end
      STEP_IN: begin
        op.a_sel = MA_S;
        op.b_sel = MB_GIN;
      end
      STEP_ST1: begin
        op.a_sel = MA_C1;
        op.b_sel = MB_GS1;
        op.x_sel = AX_ACC;
        op.y_sel = AY_M;
      end
      STEP_ST2: begin
        op.a_sel = MA_C2;
        op.b_sel = MB_GS2;
        op.x_sel = AX_ACC;
        op.y_sel = AY_M;
        op.dst   = DST_VO;
      end
      STEP_GAIN: begin
        op.a_sel = MA_VO;
        op.b_sel = MB_NODE;
        op.x_sel = AX_VO;
        op.y_sel = AY_M;
      end
      STEP_CRES: begin
        op.a_sel = MA_C2;
        op.b_sel = MB_RES;
        op.x_sel = AX_ACC;
        op.y_sel = AY_M;
        op.sub   = ~band;
        op.dst   = DST_VA;
      end
      STEP_DIFF1: begin
        op.uses_mul = 1'b0;
        op.x_sel    = band ? AX_S : AX_VA;
        op.y_sel    = band ? AY_VA : AY_VO;
        op.sub      = 1'b1;
        op.dst      = DST_DIFF;
      end
      STEP_CAP1: begin
        op.y_sel = AY_C1;
        op.sub   = 1'b1;
        op.dst   = DST_CAP1;
      end
      STEP_DIFF2: begin
        op.uses_mul = 1'b0;
        op.x_sel    = band ? AX_VA : AX_VO;
        op.y_sel    = band ? AY_VO : AY_ZERO;
        op.sub      = band;
        op.dst      = DST_DIFF;
      end
      STEP_CAP2: begin
        op.y_sel = AY_C2;
        op.sub   = 1'b1;
        op.dst   = DST_CAP2;
      end
      default: begin
        op.uses_mul = 1'b0;
        op.dst      = DST_DIFF;
      end
    endcase
    return op;
  endfunction

endpackage

// ----- rtl/core/sallen_key_crossover_filter_top.sv -----
// Sallen-Key second-order crossover, lowpass and highpass bands per channel.
// Each accepted word is worked through fully before the next is taken: fifteen passes
// through the shared multiplier (four 32x32 products each), four adder-only steps and
// one output load, which waits while the previous result has not been taken.
// A write of cap_resistance starts a divide; no word is taken while it runs.
// Reset clears all capacitor states, the coefficient registers and the divided gain at once.
`timescale 1ns / 1ps

module sallen_key_crossover_filter_top #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // sample_in
  input  logic [0:0]    s_axis_tuser,   // channel_sel
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata    // low_band, high_band
);

  localparam logic [2:0] REG_LOW_GAIN_IN   = 3'd0;
  localparam logic [2:0] REG_LOW_GAIN_ONE  = 3'd1;
  localparam logic [2:0] REG_LOW_GAIN_TWO  = 3'd2;
  localparam logic [2:0] REG_HIGH_GAIN_IN  = 3'd3;
  localparam logic [2:0] REG_HIGH_GAIN_ONE = 3'd4;
  localparam logic [2:0] REG_HIGH_GAIN_TWO = 3'd5;
  localparam logic [2:0] REG_CAP_RES       = 3'd6;
  localparam logic [2:0] REG_TWO_OVER_RES  = 3'd7;

  skcf_pkg::coef_t    coef_q, coef_d;
  skcf_pkg::cmd_t     cmd;
  skcf_pkg::sts_t     sts;
  logic               cfg_we, div_start;
  logic [2:0]         reg_idx;
  logic signed [63:0] low_band, high_band;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[5:3];
  assign cfg_we    = psel & penable & pwrite;
  assign div_start = cfg_we && (reg_idx == REG_CAP_RES);

  always_comb begin
    coef_d = coef_q;
    if (cfg_we) begin
      case (reg_idx)
        REG_LOW_GAIN_IN:   coef_d.low_gain_in             = pwdata;
        REG_LOW_GAIN_ONE:  coef_d.low_gain_state_one      = pwdata;
        REG_LOW_GAIN_TWO:  coef_d.low_gain_state_two      = pwdata;
        REG_HIGH_GAIN_IN:  coef_d.high_gain_in            = pwdata;
        REG_HIGH_GAIN_ONE: coef_d.high_gain_state_one     = pwdata;
        REG_HIGH_GAIN_TWO: coef_d.high_gain_state_two     = pwdata;
        REG_CAP_RES:       coef_d.cap_resistance          = pwdata[62:0];
        REG_TWO_OVER_RES:  coef_d.two_over_cap_resistance = pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOW_GAIN_IN:   prdata = coef_q.low_gain_in;
      REG_LOW_GAIN_ONE:  prdata = coef_q.low_gain_state_one;
      REG_LOW_GAIN_TWO:  prdata = coef_q.low_gain_state_two;
      REG_HIGH_GAIN_IN:  prdata = coef_q.high_gain_in;
      REG_HIGH_GAIN_ONE: prdata = coef_q.high_gain_state_one;
      REG_HIGH_GAIN_TWO: prdata = coef_q.high_gain_state_two;
      REG_CAP_RES:       prdata = {1'b0, coef_q.cap_resistance};
      REG_TWO_OVER_RES:  prdata = {1'b0, coef_q.two_over_cap_resistance};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  skcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  skcf_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .coef_i      (coef_q),
    .div_start_i (div_start),
    .sample_i    (s_axis_tdata),
    .channel_i   (s_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .low_band_o  (low_band),
    .high_band_o (high_band)
  );

  assign m_axis_tdata = {high_band, low_band};

endmodule

// ----- rtl/core/skcf_mul.sv -----
// Multi-cycle signed Q31.32 multiplier with saturation, one 32x32 product a cycle.
// Depends on skcf_pkg for the saturation limits.
`timescale 1ns / 1ps

module skcf_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] p_o
);

  localparam logic [2:0] PH_FIN = 3'd4;

  logic [63:0]        ma_q, mb_q, ma_d, mb_d;
  logic               neg_q;
  logic [127:0]       acc_q, acc_sh;
  logic [2:0]         ph_q;
  logic               busy_q, done_q;
  logic signed [63:0] p_q, fin;
  logic [31:0]        op_a, op_b;
  logic [63:0]        pp, r;

  assign ma_d = a_i[63] ? (~a_i + 64'd1) : a_i;
  assign mb_d = b_i[63] ? (~b_i + 64'd1) : b_i;

  assign op_a = ph_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign op_b = ph_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp   = 64'(op_a) * 64'(op_b);

  always_comb begin
    case (ph_q[1:0])
      2'd0:    acc_sh = {64'd0, pp};
      2'd3:    acc_sh = {pp, 64'd0};
      default: acc_sh = {32'd0, pp, 32'd0};
    endcase
  end

  assign r = acc_q[95:32];

  always_comb begin
    if (|acc_q[127:96]) begin
      fin = neg_q ? skcf_pkg::S64_MIN : skcf_pkg::S64_MAX;
    end else if (!neg_q) begin
      fin = r[63] ? skcf_pkg::S64_MAX : r;
    end else begin
      fin = r[63] ? skcf_pkg::S64_MIN : (~r + 64'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= '0;
      end else if (busy_q) begin
        if (ph_q == PH_FIN) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          ph_q <= ph_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (ph_q == PH_FIN) begin
        p_q <= fin;
      end else begin
        acc_q <= acc_q + acc_sh;
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// ----- rtl/core/skcf_div.sv -----
// Divider by the fixed resistor value: reciprocal multiply, one 32x32 product a cycle.
// Depends on skcf_pkg for the resistor constant; reads the dividend while busy.
`timescale 1ns / 1ps

module skcf_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] dividend_i,
  output logic        busy_o,
  output logic [62:0] quotient_o
);

  localparam int unsigned RECIP_SH = 63 + skcf_pkg::RES_W;
  localparam logic [63:0] RECIP    = 64'(((80'd1 << RECIP_SH) + 80'(skcf_pkg::FIXED_RES)
                                           - 80'd1) / 80'(skcf_pkg::FIXED_RES));
  localparam logic [1:0]  PH_LAST  = 2'd3;

  logic [127:0] acc_q, acc_sh;
  logic [1:0]   ph_q;
  logic         busy_q;
  logic [63:0]  dvd, pp;
  logic [31:0]  op_x, op_m;

  assign dvd  = {1'b0, dividend_i};
  assign op_x = ph_q[1] ? dvd[63:32] : dvd[31:0];
  assign op_m = ph_q[0] ? RECIP[63:32] : RECIP[31:0];
  assign pp   = 64'(op_x) * 64'(op_m);

  always_comb begin
    case (ph_q)
      2'd0:    acc_sh = {64'd0, pp};
      2'd3:    acc_sh = {pp, 64'd0};
      default: acc_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= '0;
      acc_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      ph_q   <= '0;
      acc_q  <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + acc_sh;
      if (ph_q == PH_LAST) begin
        busy_q <= 1'b0;
      end else begin
        ph_q <= ph_q + 2'd1;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = {13'd0, acc_q[127:RECIP_SH]};

endmodule

// ----- rtl/core/skcf_dp.sv -----
// Datapath: operand selection, shared multiplier, saturating adder, capacitor
// states and output word register. Depends on skcf_pkg, skcf_mul and skcf_div.
`timescale 1ns / 1ps

module skcf_dp #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  skcf_pkg::cmd_t        cmd_i,
  output skcf_pkg::sts_t        sts_o,
  input  skcf_pkg::coef_t       coef_i,
  input  logic                  div_start_i,
  input  logic signed [63:0]    sample_i,
  input  logic                  channel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [63:0]    low_band_o,
  output logic signed [63:0]    high_band_o
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [63:0] s_q, node_q, acc_q, vo_q, va_q, diff_q, lo_q;
  logic signed [63:0] out_lo_q, out_hi_q;
  logic               out_valid_q;
  logic [CH_W-1:0]    ch_q;
  logic signed [63:0] lc1_q [CHANNELS];
  logic signed [63:0] lc2_q [CHANNELS];
  logic signed [63:0] hc1_q [CHANNELS];
  logic signed [63:0] hc2_q [CHANNELS];

  logic signed [63:0] c1, c2, two_rc, high_node, mul_a, mul_b, mul_p, alu_x, alu_y, alu_r;
  logic               mul_done, div_busy, band;
  logic [62:0]        quotient;
  skcf_pkg::op_t      op;

  assign op        = cmd_i.op;
  assign band      = cmd_i.band;
  assign c1        = band ? hc1_q[ch_q] : lc1_q[ch_q];
  assign c2        = band ? hc2_q[ch_q] : lc2_q[ch_q];
  assign two_rc    = {1'b0, coef_i.two_over_cap_resistance};
  assign high_node = {1'b0, quotient};

  always_comb begin
    case (op.a_sel)
      skcf_pkg::MA_S:      mul_a = s_q;
      skcf_pkg::MA_C1:     mul_a = c1;
      skcf_pkg::MA_C2:     mul_a = c2;
      skcf_pkg::MA_VO:     mul_a = vo_q;
      skcf_pkg::MA_TWO_RC: mul_a = two_rc;
      default:             mul_a = '0;
    endcase
  end

  always_comb begin
    case (op.b_sel)
      skcf_pkg::MB_HALF: mul_b = skcf_pkg::HALF_RES_Q;
      skcf_pkg::MB_GIN:  mul_b = band ? coef_i.high_gain_in : coef_i.low_gain_in;
      skcf_pkg::MB_GS1:  mul_b = band ? coef_i.high_gain_state_one : coef_i.low_gain_state_one;
      skcf_pkg::MB_GS2:  mul_b = band ? coef_i.high_gain_state_two : coef_i.low_gain_state_two;
      skcf_pkg::MB_NODE: mul_b = band ? high_node : node_q;
      skcf_pkg::MB_RES:  mul_b = band ? {1'b0, coef_i.cap_resistance} : skcf_pkg::FIXED_RES_Q;
      skcf_pkg::MB_DIFF: mul_b = diff_q;
      default:           mul_b = '0;
    endcase
  end

  skcf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  skcf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_i),
    .dividend_i (coef_i.cap_resistance),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_comb begin
    case (op.x_sel)
      skcf_pkg::AX_M:   alu_x = mul_p;
      skcf_pkg::AX_ACC: alu_x = acc_q;
      skcf_pkg::AX_VO:  alu_x = vo_q;
      skcf_pkg::AX_VA:  alu_x = va_q;
      skcf_pkg::AX_S:   alu_x = s_q;
      default:          alu_x = '0;
    endcase
  end

  always_comb begin
    case (op.y_sel)
      skcf_pkg::AY_ZERO: alu_y = '0;
      skcf_pkg::AY_M:    alu_y = mul_p;
      skcf_pkg::AY_VO:   alu_y = vo_q;
      skcf_pkg::AY_VA:   alu_y = va_q;
      skcf_pkg::AY_C1:   alu_y = c1;
      skcf_pkg::AY_C2:   alu_y = c2;
      default:           alu_y = '0;
    endcase
  end

  assign alu_r = skcf_pkg::sat_addsub(alu_x, alu_y, op.sub);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      s_q  <= sample_i;
      ch_q <= (CHANNELS > 1) ? CH_W'(channel_i) : '0;
    end
    if (cmd_i.alu_en) begin
      case (op.dst)
        skcf_pkg::DST_NODE: node_q <= alu_r;
        skcf_pkg::DST_ACC:  acc_q  <= alu_r;
        skcf_pkg::DST_VO:   vo_q   <= alu_r;
        skcf_pkg::DST_VA:   va_q   <= alu_r;
        skcf_pkg::DST_DIFF: diff_q <= alu_r;
        default: ;
      endcase
      if (cmd_i.lo_latch) begin
        lo_q <= vo_q;
      end
    end
    if (cmd_i.out_load) begin
      out_lo_q <= lo_q;
      out_hi_q <= (vo_q == skcf_pkg::S64_MIN) ? skcf_pkg::S64_MAX : -vo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lc1_q[i] <= '0;
        lc2_q[i] <= '0;
        hc1_q[i] <= '0;
        hc2_q[i] <= '0;
      end
    end else if (cmd_i.alu_en) begin
      if (op.dst == skcf_pkg::DST_CAP1) begin
        if (band) begin
          hc1_q[ch_q] <= alu_r;
        end else begin
          lc1_q[ch_q] <= alu_r;
        end
      end
      if (op.dst == skcf_pkg::DST_CAP2) begin
        if (band) begin
          hc2_q[ch_q] <= alu_r;
        end else begin
          lc2_q[ch_q] <= alu_r;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign low_band_o  = out_lo_q;
  assign high_band_o = out_hi_q;

endmodule

// ----- rtl/core/skcf_ctrl.sv -----
// Controller: steps both filter bands through the datapath for one word.
// Depends on skcf_pkg for the step table and command/status types.
`timescale 1ns / 1ps

module skcf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  skcf_pkg::sts_t sts_i,
  output skcf_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]      state_q, state_d;
  skcf_pkg::step_e step_q, step_d, step_nxt;
  logic            band_q, band_d, band_nxt, last;
  logic [1:0]      state_nxt;
  skcf_pkg::op_t   op;

  assign op = skcf_pkg::step_op(step_q, band_q);

  always_comb begin
    last      = (step_q == skcf_pkg::STEP_CAP2) && band_q;
    step_nxt  = skcf_pkg::step_e'(step_q + 4'd1);
    band_nxt  = band_q;
    state_nxt = ST_ISSUE;
    if (step_q == skcf_pkg::STEP_CAP2) begin
      step_nxt = skcf_pkg::STEP_IN;
      band_nxt = 1'b1;
      if (band_q) begin
        state_nxt = ST_FINISH;
      end
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = op;
    cmd_o.band     = band_q;
    cmd_o.lo_latch = (step_q == skcf_pkg::STEP_CAP2) && !band_q;
    in_ready_o     = (state_q == ST_IDLE) && !sts_i.div_busy;
    state_d        = state_q;
    step_d         = step_q;
    band_d         = band_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_ISSUE;
          step_d        = skcf_pkg::STEP_NODE;
          band_d        = 1'b0;
        end
      end
      ST_ISSUE: begin
        if (op.uses_mul) begin
          cmd_o.mul_go = 1'b1;
          state_d      = ST_WAIT;
        end else begin
          cmd_o.alu_en = 1'b1;
          state_d      = state_nxt;
          step_d       = step_nxt;
          band_d       = band_nxt;
        end
      end
      ST_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.alu_en = 1'b1;
          state_d      = state_nxt;
          if (!last) begin
            step_d = step_nxt;
            band_d = band_nxt;
          end
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= skcf_pkg::STEP_NODE;
      band_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      band_q  <= band_d;
    end
  end

endmodule
